### hdl/register_vm_execute_unit_assert.svh
// Assertion macros used by the execute unit back end.
`ifndef REGISTER_VM_EXECUTE_UNIT_ASSERT_SVH
`define REGISTER_VM_EXECUTE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RVX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RVX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVX_ASSERT(lbl, prop, msg)
`define RVX_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hdl/rvx_pkg.sv
// Shared types and constants of the register VM execute unit.
`default_nettype none
package rvx_pkg;

  localparam int REG_INDEX_BITS_DEF = 16;
  localparam int SLOT_W             = 16;
  localparam int PC_W               = 32;
  localparam int DATA_W             = 64;
  localparam int Q_DEPTH            = 2;
  localparam int Q_PTR_W            = $clog2(Q_DEPTH);
  localparam int Q_CNT_W            = $clog2(Q_DEPTH + 1);
  localparam int RESULT_REG         = 3;
  localparam logic [PC_W-1:0] INSN_BYTES = 32'd8;

  localparam logic [2:0] OPC_END = 3'd0;
  localparam logic [2:0] OPC_LDI = 3'd1;
  localparam logic [2:0] OPC_ADD = 3'd2;
  localparam logic [2:0] OPC_SUB = 3'd3;
  localparam logic [2:0] OPC_JZ  = 3'd4;
  localparam logic [2:0] OPC_JMP = 3'd5;

  typedef enum logic [2:0] {
    K_END, K_LDI, K_ADD, K_SUB, K_JZ, K_JMP, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              wr_en;
    logic [SLOT_W-1:0] slot_a;
    logic [SLOT_W-1:0] slot_b;
    logic [SLOT_W-1:0] slot_c;
  } dec_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     finished;
    logic signed [DATA_W-1:0] value;
  } res_t;

endpackage
`default_nettype wire

### hdl/rvx_front.sv
// Front end: decodes incoming instructions and buffers them for the back end.
`default_nettype none
module rvx_front
  import rvx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr_busy,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [2:0]        in_op,
  input  wire logic [SLOT_W-1:0] in_slot_a,
  input  wire logic [SLOT_W-1:0] in_slot_b,
  input  wire logic [SLOT_W-1:0] in_slot_c,
  output logic                   q_vld,
  output dec_t                   q_item,
  input  wire logic              q_pop
);

  dec_t               dec;
  dec_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_ok;

  always_comb begin
    dec.slot_a = in_slot_a;
    dec.slot_b = in_slot_b;
    dec.slot_c = in_slot_c;
    unique case (in_op)
      OPC_END: begin dec.kind = K_END; dec.wr_en = 1'b0; end
      OPC_LDI: begin dec.kind = K_LDI; dec.wr_en = 1'b1; end
      OPC_ADD: begin dec.kind = K_ADD; dec.wr_en = 1'b1; end
      OPC_SUB: begin dec.kind = K_SUB; dec.wr_en = 1'b1; end
      OPC_JZ:  begin dec.kind = K_JZ;  dec.wr_en = 1'b0; end
      OPC_JMP: begin dec.kind = K_JMP; dec.wr_en = 1'b0; end
      default: begin dec.kind = K_NOP; dec.wr_en = 1'b0; end
    endcase
  end

  assign in_full = clr_busy || (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push_ok = in_push && !in_full;
  assign q_vld   = (cnt_r != '0);
  assign q_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push_ok, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/rvx_back.sv
// Back end: register file, program counter and the execute stage.
`default_nettype none
`include "register_vm_execute_unit_assert.svh"
module rvx_back
  import rvx_pkg::*;
#(
  parameter int REG_INDEX_BITS = REG_INDEX_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  output logic      clr_busy,
  input  wire logic q_vld,
  input  wire dec_t q_item,
  output logic      q_pop,
  output logic      res_vld,
  output res_t      res,
  input  wire logic res_rdy
);

  localparam int RegCount = 1 << REG_INDEX_BITS;
  localparam int IW       = REG_INDEX_BITS;

  logic [DATA_W-1:0] rf_mem [RegCount];

  logic              clr_busy_r;
  logic [IW-1:0]     clr_idx_r;
  logic              x_vld_r;
  dec_t              x_item_r;
  logic [PC_W-1:0]   pc_r;
  logic [DATA_W-1:0] rd_a_r, rd_b_r, fwd_data_r;
  logic              fwd_a_r, fwd_b_r;

  logic              x_go, x_load, x_wr;
  logic [IW-1:0]     ra_addr, rb_addr, x_waddr;
  logic [DATA_W-1:0] op_a, op_b, x_wdata;
  logic [PC_W-1:0]   x_off, pc_nxt;
  logic              rf_we;
  logic [IW-1:0]     rf_waddr;
  logic [DATA_W-1:0] rf_wdata;

  assign clr_busy = clr_busy_r;
  assign x_go     = x_vld_r && res_rdy;
  assign x_load   = q_vld && !clr_busy_r && (!x_vld_r || x_go);
  assign q_pop    = x_load;

  assign ra_addr = (q_item.kind == K_END) ? IW'(RESULT_REG) : q_item.slot_a[IW-1:0];
  assign rb_addr = q_item.slot_b[IW-1:0];

  assign op_a = fwd_a_r ? fwd_data_r : rd_a_r;
  assign op_b = fwd_b_r ? fwd_data_r : rd_b_r;

  always_comb begin
    x_waddr = x_item_r.slot_c[IW-1:0];
    x_wdata = op_b + op_a;
    x_off   = '0;
    unique case (x_item_r.kind)
      K_LDI: begin
        x_waddr = x_item_r.slot_a[IW-1:0];
        x_wdata = {{(DATA_W-32){x_item_r.slot_c[SLOT_W-1]}},
                   x_item_r.slot_c, x_item_r.slot_b};
      end
      K_SUB: x_wdata = op_b - op_a;
      K_JZ: begin
        if (op_a == '0) begin
          x_off = {x_item_r.slot_c, x_item_r.slot_b};
        end
      end
      K_JMP: x_off = {x_item_r.slot_b, x_item_r.slot_a};
      default: ;
    endcase
    pc_nxt = (x_item_r.kind == K_END) ? '0 : pc_r + x_off + INSN_BYTES;
  end

  assign x_wr = x_go && x_item_r.wr_en;

  assign res_vld      = x_go;
  assign res.next_pc  = pc_nxt;
  assign res.finished = (x_item_r.kind == K_END);
  assign res.value    = (x_item_r.kind == K_END) ? op_a : '0;

  assign rf_we    = clr_busy_r || x_wr;
  assign rf_waddr = clr_busy_r ? clr_idx_r : x_waddr;
  assign rf_wdata = clr_busy_r ? '0 : x_wdata;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (x_load) begin
      rd_a_r <= rf_mem[ra_addr];
      rd_b_r <= rf_mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (x_load) begin
      x_item_r   <= q_item;
      fwd_data_r <= x_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      x_vld_r    <= 1'b0;
      pc_r       <= '0;
      fwd_a_r    <= 1'b0;
      fwd_b_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (x_go) begin
        pc_r <= pc_nxt;
      end
      if (x_load) begin
        fwd_a_r <= x_wr && (x_waddr == ra_addr);
        fwd_b_r <= x_wr && (x_waddr == rb_addr);
      end
      if (x_load) begin
        x_vld_r <= 1'b1;
      end else if (x_go) begin
        x_vld_r <= 1'b0;
      end
    end
  end

  `RVX_ASSERT_RST(a_rst_idle, !rst_n |=> clr_busy_r && !x_vld_r, "Reset must start clearing.")
  `RVX_ASSERT(a_clear_done, $fell(clr_busy_r) |-> clr_idx_r == '0, "Clear pass ended early.")
  `RVX_ASSERT(a_end_pc, (x_go && res.finished) |=> pc_r == '0, "End must restart the PC.")
  `RVX_ASSERT(a_stall_hold, (x_vld_r && !res_rdy) |=> x_vld_r && $stable(pc_r), "Stall lost item.")

endmodule
`default_nettype wire

### hdl/rvx_outq.sv
// Result queue that holds finished items until they are popped.
`default_nettype none
module rvx_outq
  import rvx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         res_vld,
  input  wire res_t         res,
  output logic              res_rdy,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [PC_W-1:0]   out_next_pc,
  output logic              out_finished,
  output logic signed [DATA_W-1:0] out_result_value
);

  res_t               ent_r [Q_DEPTH];
  res_t               head;
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               pop_ok;

  assign res_rdy   = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign pop_ok    = out_pop && !out_empty;
  assign head      = ent_r[rd_ptr_r];

  assign out_next_pc      = head.next_pc;
  assign out_finished     = head.finished;
  assign out_result_value = head.value;

  always_comb begin
    unique case ({res_vld, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      ent_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/register_vm_execute_unit.sv
// Top level of the register VM execute unit.
//
//   Channel   Handshake        Payload
//   input     in_push/in_full  in_op, in_slot_a, in_slot_b, in_slot_c
//   result    out_pop/out_empty out_next_pc, out_finished, out_result_value
//
// One instruction retires per cycle when not stalled; the single execute
// stage with its forwarded register read sets that figure. A result passes
// the input queue, the execute stage register and the result queue. After
// reset the register file is cleared one entry a cycle with in_full held
// high. Each side stalls on its own behind a two-entry queue.
`default_nettype none
module register_vm_execute_unit
  import rvx_pkg::*;
#(
  parameter int REG_INDEX_BITS = REG_INDEX_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [2:0]        in_op,
  input  wire logic [SLOT_W-1:0] in_slot_a,
  input  wire logic [SLOT_W-1:0] in_slot_b,
  input  wire logic [SLOT_W-1:0] in_slot_c,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [PC_W-1:0]        out_next_pc,
  output logic                   out_finished,
  output logic signed [DATA_W-1:0] out_result_value
);

  logic clr_busy, q_vld, q_pop, res_vld, res_rdy;
  dec_t q_item;
  res_t res;

  rvx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_busy  (clr_busy),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_slot_a (in_slot_a),
    .in_slot_b (in_slot_b),
    .in_slot_c (in_slot_c),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  rvx_back #(
    .REG_INDEX_BITS (REG_INDEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_vld  (res_vld),
    .res      (res),
    .res_rdy  (res_rdy)
  );

  rvx_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_vld          (res_vld),
    .res              (res),
    .res_rdy          (res_rdy),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_next_pc      (out_next_pc),
    .out_finished     (out_finished),
    .out_result_value (out_result_value)
  );

endmodule
`default_nettype wire
